### sv/cct_pkg.sv
// Shared widths, constants, codes and the month table of the calendar counter.
package cct_pkg;

   localparam int EPOCH_YEAR = 1960;

   localparam int SEC_W   = 6;
   localparam int MIN_W   = 6;
   localparam int HOUR_W  = 5;
   localparam int MDAY_W  = 5;
   localparam int WDAY_W  = 3;
   localparam int MONTH_W = 4;
   localparam int YEAR_W  = 8;
   // full Gregorian year: EPOCH_YEAR up to 4095 plus an offset up to 255
   localparam int FULL_YEAR_W = 13;

   localparam int SEC_LIMIT  = 60;
   localparam int MIN_LIMIT  = 60;
   localparam int HOUR_LIMIT = 24;
   localparam int WDAY_MAX   = 7;
   localparam int MONTH_MAX  = 12;

   localparam logic ACTION_TICK = 1'b0;
   localparam logic ACTION_LOAD = 1'b1;

   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;

   typedef struct packed {
      logic [SEC_W-1:0]   cur_second;
      logic [MIN_W-1:0]   cur_minute;
      logic [HOUR_W-1:0]  cur_hour;
      logic [MDAY_W-1:0]  cur_mday;
      logic [WDAY_W-1:0]  cur_wday;
      logic [MONTH_W-1:0] cur_month;
      logic [YEAR_W-1:0]  cur_year;
      logic               day_rolled;
   } rsp_type;

   // days in a month; anything outside 1 to 12 counts as 31 days
   function automatic logic [MDAY_W-1:0] month_length(input logic [MONTH_W-1:0] month,
                                                       input logic               leap);
      logic [MDAY_W-1:0] days;
      unique case (month)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: days = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                     days = 5'd30;
         MONTH_FEB:                                   days = leap ? 5'd29 : 5'd28;
         default:                                     days = 5'd31;
      endcase
      return days;
   endfunction

endpackage

### sv/cct_channels.sv
// Valid/ready channel interfaces for the calendar counter request and response.
interface cct_req_if
   import cct_pkg::*;
();
   logic               valid;
   logic               ready;
   logic               action;
   logic [SEC_W-1:0]   load_second;
   logic [MIN_W-1:0]   load_minute;
   logic [HOUR_W-1:0]  load_hour;
   logic [MDAY_W-1:0]  load_mday;
   logic [WDAY_W-1:0]  load_wday;
   logic [MONTH_W-1:0] load_month;
   logic [YEAR_W-1:0]  load_year;

   modport source (output valid, action, load_second, load_minute, load_hour,
                   load_mday, load_wday, load_month, load_year, input ready);
   modport sink   (input valid, action, load_second, load_minute, load_hour,
                   load_mday, load_wday, load_month, load_year, output ready);
endinterface

interface cct_rsp_if
   import cct_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [SEC_W-1:0]   cur_second;
   logic [MIN_W-1:0]   cur_minute;
   logic [HOUR_W-1:0]  cur_hour;
   logic [MDAY_W-1:0]  cur_mday;
   logic [WDAY_W-1:0]  cur_wday;
   logic [MONTH_W-1:0] cur_month;
   logic [YEAR_W-1:0]  cur_year;
   logic               day_rolled;

   modport source (output valid, cur_second, cur_minute, cur_hour, cur_mday,
                   cur_wday, cur_month, cur_year, day_rolled, input ready);
   modport sink   (input valid, cur_second, cur_minute, cur_hour, cur_mday,
                   cur_wday, cur_month, cur_year, day_rolled, output ready);
endinterface

### sv/calendar_clock_tick.sv
// Top level of the one-second calendar counter with leap-year month lengths.
//
// Request channel (req_if): each transfer is a tick (action 0) that adds one
// second and carries into minutes, hours, day, weekday, month and year, or a
// load (action 1) that writes every field as given. Response channel (rsp_if):
// each request yields exactly one transfer with the time after it; day_rolled
// flags a tick that crossed midnight.
// The response is held in the result register, fed through the skid buffer while the receiver stalls.
// Throughput: one request per cycle while req_if.ready is high, set by the
// combinational carry chain from the state registers through the leap detect
// into the next state. A result register plus a one-entry skid buffer sit on
// the response side: while the receiver stalls one more request is taken, then
// req_if.ready drops until the receiver drains a result.
// Reset (synchronous, active high) sets 00:00:00, day 1, weekday 1, month 1,
// year offset 0 and empties both response buffers.
module calendar_clock_tick
   import cct_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   cct_req_if.sink   req_if,
   cct_rsp_if.source rsp_if
);

   logic [SEC_W-1:0]   sec_ff,   sec_in;
   logic [MIN_W-1:0]   min_ff,   min_in;
   logic [HOUR_W-1:0]  hour_ff,  hour_in;
   logic [MDAY_W-1:0]  mday_ff,  mday_in;
   logic [WDAY_W-1:0]  wday_ff,  wday_in;
   logic [MONTH_W-1:0] month_ff, month_in;
   logic [YEAR_W-1:0]  year_ff,  year_in;
   logic               rolled;

   logic               out_valid_ff,  out_valid_in;
   logic               skid_valid_ff, skid_valid_in;
   rsp_type            out_data_ff,   out_data_in;
   rsp_type            skid_data_ff,  skid_data_in;
   rsp_type            new_rsp;

   logic               leap;
   logic               accept;
   logic               pop;

   logic [SEC_W:0]     sec_inc;
   logic [MIN_W:0]     min_inc;
   logic [HOUR_W:0]    hour_inc;
   logic [MDAY_W:0]    mday_inc;
   logic [WDAY_W:0]    wday_inc;
   logic [MONTH_W:0]   month_inc;

   cct_leap u_leap (
      .year_offset (year_ff),
      .is_leap     (leap)
   );

   assign req_if.ready = !skid_valid_ff;
   assign accept       = req_if.valid && req_if.ready;
   assign pop          = out_valid_ff && rsp_if.ready;

   always_comb begin
      sec_inc   = {1'b0, sec_ff}   + (SEC_W+1)'(1);
      min_inc   = {1'b0, min_ff}   + (MIN_W+1)'(1);
      hour_inc  = {1'b0, hour_ff}  + (HOUR_W+1)'(1);
      mday_inc  = {1'b0, mday_ff}  + (MDAY_W+1)'(1);
      wday_inc  = {1'b0, wday_ff}  + (WDAY_W+1)'(1);
      month_inc = {1'b0, month_ff} + (MONTH_W+1)'(1);

      sec_in   = sec_ff;
      min_in   = min_ff;
      hour_in  = hour_ff;
      mday_in  = mday_ff;
      wday_in  = wday_ff;
      month_in = month_ff;
      year_in  = year_ff;
      rolled   = 1'b0;

      if (req_if.action == ACTION_LOAD) begin
         sec_in   = req_if.load_second;
         min_in   = req_if.load_minute;
         hour_in  = req_if.load_hour;
         mday_in  = req_if.load_mday;
         wday_in  = req_if.load_wday;
         month_in = req_if.load_month;
         year_in  = req_if.load_year;
      end else if (sec_inc < (SEC_W+1)'(SEC_LIMIT)) begin
         sec_in = sec_inc[SEC_W-1:0];
      end else begin
         sec_in = '0;
         if (min_inc < (MIN_W+1)'(MIN_LIMIT)) begin
            min_in = min_inc[MIN_W-1:0];
         end else begin
            min_in = '0;
            if (hour_inc < (HOUR_W+1)'(HOUR_LIMIT)) begin
               hour_in = hour_inc[HOUR_W-1:0];
            end else begin
               hour_in = '0;
               rolled  = 1'b1;
               wday_in = (wday_inc > (WDAY_W+1)'(WDAY_MAX)) ? WDAY_W'(1)
                                                            : wday_inc[WDAY_W-1:0];
               if (mday_inc > {1'b0, month_length(month_ff, leap)}) begin
                  mday_in = MDAY_W'(1);
                  if (month_inc > (MONTH_W+1)'(MONTH_MAX)) begin
                     month_in = MONTH_W'(1);
                     year_in  = year_ff + YEAR_W'(1);
                  end else begin
                     month_in = month_inc[MONTH_W-1:0];
                  end
               end else begin
                  mday_in = mday_inc[MDAY_W-1:0];
               end
            end
         end
      end

      new_rsp.cur_second = sec_in;
      new_rsp.cur_minute = min_in;
      new_rsp.cur_hour   = hour_in;
      new_rsp.cur_mday   = mday_in;
      new_rsp.cur_wday   = wday_in;
      new_rsp.cur_month  = month_in;
      new_rsp.cur_year   = year_in;
      new_rsp.day_rolled = rolled;
   end

   // result register with one-entry skid
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_valid_ff && !pop) begin
         if (accept) begin
            skid_valid_in = 1'b1;
            skid_data_in  = new_rsp;
         end
      end else if (skid_valid_ff) begin
         out_valid_in  = 1'b1;
         out_data_in   = skid_data_ff;
         skid_valid_in = 1'b0;
      end else begin
         out_valid_in = accept;
         out_data_in  = new_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sec_ff        <= '0;
         min_ff        <= '0;
         hour_ff       <= '0;
         mday_ff       <= MDAY_W'(1);
         wday_ff       <= WDAY_W'(1);
         month_ff      <= MONTH_W'(1);
         year_ff       <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            sec_ff   <= sec_in;
            min_ff   <= min_in;
            hour_ff  <= hour_in;
            mday_ff  <= mday_in;
            wday_ff  <= wday_in;
            month_ff <= month_in;
            year_ff  <= year_in;
         end
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_if.valid      = out_valid_ff;
   assign rsp_if.cur_second = out_data_ff.cur_second;
   assign rsp_if.cur_minute = out_data_ff.cur_minute;
   assign rsp_if.cur_hour   = out_data_ff.cur_hour;
   assign rsp_if.cur_mday   = out_data_ff.cur_mday;
   assign rsp_if.cur_wday   = out_data_ff.cur_wday;
   assign rsp_if.cur_month  = out_data_ff.cur_month;
   assign rsp_if.cur_year   = out_data_ff.cur_year;
   assign rsp_if.day_rolled = out_data_ff.day_rolled;

   // skid only fills behind a held result
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry without a held result");

   // a midnight crossing always lands on 00:00:00
   a_rolled_midnight: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.day_rolled) |->
         (rsp_if.cur_hour == '0 && rsp_if.cur_minute == '0 && rsp_if.cur_second == '0))
      else $error("day_rolled without midnight time");

   // a plain tick below the seconds wrap adds exactly one second
   a_tick_adds_second: assert property (@(posedge clock) disable iff (reset)
      (accept && req_if.action == ACTION_TICK && sec_ff < SEC_W'(SEC_LIMIT - 2)) |=>
         (sec_ff == $past(sec_ff) + SEC_W'(1) && min_ff == $past(min_ff)))
      else $error("tick did not advance seconds by one");

endmodule

### sv/cct_leap.sv
// Gregorian leap-year detect for epoch plus year offset.
module cct_leap
   import cct_pkg::*;
(
   input  logic [YEAR_W-1:0] year_offset,
   output logic              is_leap
);

   // y / 25 as (y * 5243) >> 17, exact for y below 8192
   localparam int          DIV25_SHIFT = 17;
   localparam int          PROD_W      = 2 * FULL_YEAR_W;
   localparam int          QUOT_W      = PROD_W - DIV25_SHIFT;
   localparam logic [FULL_YEAR_W-1:0] DIV25_MULT = FULL_YEAR_W'(5243);
   localparam logic [FULL_YEAR_W-1:0] EPOCH_FULL = FULL_YEAR_W'(EPOCH_YEAR);

   logic [FULL_YEAR_W-1:0] full_year;
   logic [PROD_W-1:0]      prod;
   logic [QUOT_W-1:0]      quot;
   logic [FULL_YEAR_W-1:0] quot_x25;
   logic                   div4;
   logic                   div16;
   logic                   div25;

   always_comb begin
      full_year = EPOCH_FULL + {{(FULL_YEAR_W-YEAR_W){1'b0}}, year_offset};
      prod      = {{FULL_YEAR_W{1'b0}}, full_year} * {{FULL_YEAR_W{1'b0}}, DIV25_MULT};
      quot      = prod[PROD_W-1:DIV25_SHIFT];
      quot_x25  = {quot, 4'b0000} + {1'b0, quot, 3'b000} + {4'b0000, quot};
      div25     = (full_year == quot_x25);
      div4      = (full_year[1:0] == 2'b00);
      div16     = (full_year[3:0] == 4'b0000);
      // by 100 = by 4 and 25, by 400 = by 16 and 25
      is_leap   = (div4 && !div25) || (div16 && div25);
   end

endmodule

### tb/calendar_clock_tick_tb.sv
// Self-checking testbench for the calendar counter: ticks, loads, rollovers and stalls.
module calendar_clock_tick_tb;
   import cct_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUIET_LIMIT = 2000;
   localparam int HOLD_CYCLES = 80;

   typedef struct packed {
      logic               action;
      logic [SEC_W-1:0]   load_second;
      logic [MIN_W-1:0]   load_minute;
      logic [HOUR_W-1:0]  load_hour;
      logic [MDAY_W-1:0]  load_mday;
      logic [WDAY_W-1:0]  load_wday;
      logic [MONTH_W-1:0] load_month;
      logic [YEAR_W-1:0]  load_year;
   } time_req_type;

   logic clock;
   logic reset;

   cct_req_if req_ch ();
   cct_rsp_if rsp_ch ();

   calendar_clock_tick uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   int month_len [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

   rsp_type calendar_now;
   rsp_type expected_times[$];

   bit req_idling;
   bit rsp_idling;
   int rsp_hold_len;
   int n_errors;
   int n_checked;
   int n_ticks;
   int n_loads;
   int n_midnights;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic bit is_leap(input int year);
      return ((year % 4) == 0 && (year % 100) != 0) || (year % 400) == 0;
   endfunction

   function automatic int days_in_month(input int month, input int year_off);
      if (month < 1 || month > MONTH_MAX)
         return 31;
      if (month == MONTH_FEB && is_leap(EPOCH_YEAR + year_off))
         return 29;
      return month_len[month-1];
   endfunction

   // time after one request, counters carried as int, wider than stored
   function automatic rsp_type advance_calendar(input rsp_type t, input time_req_type r);
      rsp_type n;
      int s, mi, h, d, w, mo;
      n = t;
      n.day_rolled = 1'b0;
      if (r.action == ACTION_LOAD) begin
         n.cur_second = r.load_second;
         n.cur_minute = r.load_minute;
         n.cur_hour   = r.load_hour;
         n.cur_mday   = r.load_mday;
         n.cur_wday   = r.load_wday;
         n.cur_month  = r.load_month;
         n.cur_year   = r.load_year;
         return n;
      end
      s = int'(t.cur_second) + 1;
      if (s >= SEC_LIMIT) begin
         n.cur_second = '0;
         mi = int'(t.cur_minute) + 1;
         if (mi >= MIN_LIMIT) begin
            n.cur_minute = '0;
            h = int'(t.cur_hour) + 1;
            if (h >= HOUR_LIMIT) begin
               n.cur_hour   = '0;
               n.day_rolled = 1'b1;
               w = int'(t.cur_wday) + 1;
               n.cur_wday = (w > WDAY_MAX) ? WDAY_W'(1) : WDAY_W'(w);
               d = int'(t.cur_mday) + 1;
               if (d > days_in_month(int'(t.cur_month), int'(t.cur_year))) begin
                  n.cur_mday = MDAY_W'(1);
                  mo = int'(t.cur_month) + 1;
                  if (mo > MONTH_MAX) begin
                     n.cur_month = MONTH_W'(1);
                     n.cur_year  = t.cur_year + YEAR_W'(1);
                  end else begin
                     n.cur_month = MONTH_W'(mo);
                  end
               end else begin
                  n.cur_mday = MDAY_W'(d);
               end
            end else begin
               n.cur_hour = HOUR_W'(h);
            end
         end else begin
            n.cur_minute = MIN_W'(mi);
         end
      end else begin
         n.cur_second = SEC_W'(s);
      end
      return n;
   endfunction

   function automatic time_req_type tick_req();
      time_req_type r;
      r = '0;
      r.action = ACTION_TICK;
      return r;
   endfunction

   function automatic time_req_type load_req(input int s, input int mi, input int h,
                                             input int d, input int w, input int mo,
                                             input int y);
      time_req_type r;
      r.action      = ACTION_LOAD;
      r.load_second = SEC_W'(s);
      r.load_minute = MIN_W'(mi);
      r.load_hour   = HOUR_W'(h);
      r.load_mday   = MDAY_W'(d);
      r.load_wday   = WDAY_W'(w);
      r.load_month  = MONTH_W'(mo);
      r.load_year   = YEAR_W'(y);
      return r;
   endfunction

   // mostly ticks; loads favor the last seconds before midnight at a month end
   function automatic time_req_type random_request();
      int pick, mo, y;
      pick = $urandom_range(0, 99);
      if (pick < 70)
         return tick_req();
      if (pick < 85) begin
         mo = ($urandom_range(0, 2) == 0) ? int'(MONTH_FEB) : $urandom_range(1, 12);
         y  = $urandom_range(0, 255);
         return load_req(SEC_LIMIT - 1 - $urandom_range(0, 4), MIN_LIMIT - 1, HOUR_LIMIT - 1,
                         days_in_month(mo, y) - $urandom_range(0, 1),
                         $urandom_range(1, 7), mo, y);
      end
      if (pick < 95)
         return load_req($urandom_range(0, 59), $urandom_range(0, 59), $urandom_range(0, 23),
                         $urandom_range(1, 31), $urandom_range(1, 7), $urandom_range(1, 12),
                         $urandom_range(0, 255));
      return load_req($urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 31),
                      $urandom_range(0, 31), $urandom_range(0, 7), $urandom_range(0, 15),
                      $urandom_range(0, 255));
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t ns mismatch: %s", $realtime, msg);
      n_errors++;
   endtask

   task automatic check_field(input string name, input int got, input int want);
      if (got != want)
         report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
   endtask

   task automatic send_time_request(input time_req_type r);
      if (req_idling && $urandom_range(0, 5) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.action      <= r.action;
      req_ch.load_second <= r.load_second;
      req_ch.load_minute <= r.load_minute;
      req_ch.load_hour   <= r.load_hour;
      req_ch.load_mday   <= r.load_mday;
      req_ch.load_wday   <= r.load_wday;
      req_ch.load_month  <= r.load_month;
      req_ch.load_year   <= r.load_year;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic wait_for_drain();
      req_ch.valid <= 1'b0;
      while (expected_times.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // receiver: random stall bursts, plus a long hold-off on request
   initial begin : rsp_ready_gen
      int gap;
      gap = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_len > 0) begin
            gap = rsp_hold_len;
            rsp_hold_len = 0;
         end else if (gap == 0 && rsp_idling && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 17);
         end
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            gap--;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // check the response first, then record the request of the same edge
   always @(posedge clock) begin : transfer_monitor
      rsp_type got, want;
      time_req_type r;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.cur_second = rsp_ch.cur_second;
            got.cur_minute = rsp_ch.cur_minute;
            got.cur_hour   = rsp_ch.cur_hour;
            got.cur_mday   = rsp_ch.cur_mday;
            got.cur_wday   = rsp_ch.cur_wday;
            got.cur_month  = rsp_ch.cur_month;
            got.cur_year   = rsp_ch.cur_year;
            got.day_rolled = rsp_ch.day_rolled;
            if (expected_times.size() == 0) begin
               report_mismatch("response transfer with nothing expected");
            end else begin
               want = expected_times.pop_front();
               check_field("cur_second", got.cur_second, want.cur_second);
               check_field("cur_minute", got.cur_minute, want.cur_minute);
               check_field("cur_hour", got.cur_hour, want.cur_hour);
               check_field("cur_mday", got.cur_mday, want.cur_mday);
               check_field("cur_wday", got.cur_wday, want.cur_wday);
               check_field("cur_month", got.cur_month, want.cur_month);
               check_field("cur_year", got.cur_year, want.cur_year);
               check_field("day_rolled", got.day_rolled, want.day_rolled);
               n_checked++;
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            r.action      = req_ch.action;
            r.load_second = req_ch.load_second;
            r.load_minute = req_ch.load_minute;
            r.load_hour   = req_ch.load_hour;
            r.load_mday   = req_ch.load_mday;
            r.load_wday   = req_ch.load_wday;
            r.load_month  = req_ch.load_month;
            r.load_year   = req_ch.load_year;
            calendar_now = advance_calendar(calendar_now, r);
            expected_times.push_back(calendar_now);
            if (r.action == ACTION_LOAD)
               n_loads++;
            else
               n_ticks++;
            if (calendar_now.day_rolled)
               n_midnights++;
         end
      end
   end

   always @(posedge clock) begin : watchdog
      int quiet;
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet = 0;
      end else begin
         quiet++;
         if (quiet >= QUIET_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   task automatic test_directed();
      req_idling = 1'b1;
      rsp_idling = 1'b1;
      send_time_request(tick_req());
      // year offset wraps past 255 on New Year
      send_time_request(load_req(59, 59, 23, 31, 7, 12, 255));
      send_time_request(tick_req());
      // 2000 is a leap year
      send_time_request(load_req(59, 59, 23, 28, 3, 2, 40));
      send_time_request(tick_req());
      // 2100 is not
      send_time_request(load_req(59, 59, 23, 28, 5, 2, 140));
      send_time_request(tick_req());
      send_time_request(load_req(59, 59, 23, 29, 1, 2, 100));
      send_time_request(tick_req());
      send_time_request(load_req(59, 59, 23, 30, 2, 4, 0));
      send_time_request(tick_req());
      // all fields at their widest, seconds, minutes, hour and month out of range
      send_time_request(load_req(63, 63, 31, 31, 7, 15, 255));
      send_time_request(tick_req());
      send_time_request(load_req(0, 0, 0, 0, 0, 0, 0));
      send_time_request(tick_req());
      // month zero counts as 31 days
      send_time_request(load_req(59, 59, 23, 0, 0, 0, 0));
      send_time_request(tick_req());
      send_time_request(load_req(59, 59, 23, 31, 6, 13, 17));
      send_time_request(tick_req());
      send_time_request(load_req(59, 10, 5, 15, 4, 6, 88));
      send_time_request(tick_req());
      send_time_request(load_req(59, 59, 5, 15, 4, 6, 88));
      send_time_request(tick_req());
      send_time_request(load_req(59, 59, 23, 31, 2, 1, 5));
      send_time_request(tick_req());
   endtask

   task automatic test_random();
      for (int i = 0; i < 950; i++) begin
         if (i % 64 == 0) begin
            req_idling = ($urandom_range(0, 3) != 0);
            rsp_idling = ($urandom_range(0, 3) != 0);
         end
         send_time_request(random_request());
      end
   endtask

   // receiver holds off while requests keep coming, then the sender drains
   task automatic test_backpressure();
      req_idling = 1'b0;
      rsp_idling = 1'b0;
      wait_for_drain();
      rsp_hold_len = HOLD_CYCLES;
      for (int i = 0; i < 24; i++)
         send_time_request(random_request());
      wait_for_drain();
   endtask

   task automatic test_steady_stream();
      req_idling = 1'b0;
      rsp_idling = 1'b0;
      for (int i = 0; i < 150; i++)
         send_time_request(random_request());
   endtask

   initial begin
      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.action      <= ACTION_TICK;
      req_ch.load_second <= '0;
      req_ch.load_minute <= '0;
      req_ch.load_hour   <= '0;
      req_ch.load_mday   <= '0;
      req_ch.load_wday   <= '0;
      req_ch.load_month  <= '0;
      req_ch.load_year   <= '0;
      calendar_now = '{cur_second: '0, cur_minute: '0, cur_hour: '0, cur_mday: MDAY_W'(1),
                       cur_wday: WDAY_W'(1), cur_month: MONTH_W'(1), cur_year: '0,
                       day_rolled: 1'b0};
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random();
      test_backpressure();
      test_steady_stream();
      wait_for_drain();
      $display("Covered %0d ticks and %0d loads, %0d of them crossing midnight;",
               n_ticks, n_loads, n_midnights);
      $display("%0d responses checked, %0d mismatches", n_checked, n_errors);
      if (n_errors == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

### filelist.f
sv/cct_pkg.sv
sv/cct_channels.sv
sv/cct_leap.sv
sv/calendar_clock_tick.sv
tb/calendar_clock_tick_tb.sv
